### sv/rational_arithmetic_unit_defines.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
// Implication check under synchronous reset.
`define RAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau check failed");
// Next-cycle implication check.
`define RAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau check failed");
`endif

### sv/rau_pkg.sv
// Package: types, constants and status codes for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int VALUE_WIDTH = 32;
  localparam int MAG_W = 64;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
    OP_DIV = 3'd4, OP_NEG = 3'd5, OP_EQ = 3'd6, OP_LT = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_OVERFLOW = 2'd2, ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    logic [1:0]         status;
  } out_beat_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic             direct;   // result already final
    out_beat_t        res;      // final result if direct
    op_t              op;
    logic             na;       // sign of a
    logic             nb;       // sign of b
    logic [31:0]      an;       // magnitudes
    logic [31:0]      ad;
    logic [31:0]      bn;
    logic [31:0]      bd;
  } job_t;

  localparam int QDEPTH = 2;
endpackage

### sv/rau_front.sv
// Front part: takes the operand beat, extracts magnitudes and screens zero denominators.
`timescale 1ns / 1ps
module rau_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rau_pkg::in_beat_t in_beat,
  input  logic              q_full,
  output logic              busy,
  output logic              q_push,
  output rau_pkg::job_t     q_data
);
  import rau_pkg::*;

  logic        vld_r;
  in_beat_t    hold_r;
  logic        an_s, ad_s, bn_s, bd_s;
  logic [31:0] an_m, ad_m, bn_m, bd_m;
  logic        uses_b;
  op_t         op;

  function automatic logic [31:0] fld_mag(input logic [31:0] raw);
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] m;
    v = raw[VALUE_WIDTH-1:0];
    m = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    return 32'(m);
  endfunction

  assign busy = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (start && !busy) begin
      vld_r  <= 1'b1;
      hold_r <= in_beat;
    end else if (vld_r && !q_full) begin
      vld_r <= 1'b0;
    end
  end

  assign op   = op_t'(hold_r.operation);
  assign an_s = hold_r.a_num[VALUE_WIDTH-1];
  assign ad_s = hold_r.a_den[VALUE_WIDTH-1];
  assign bn_s = hold_r.b_num[VALUE_WIDTH-1];
  assign bd_s = hold_r.b_den[VALUE_WIDTH-1];
  assign an_m = fld_mag(hold_r.a_num);
  assign ad_m = fld_mag(hold_r.a_den);
  assign bn_m = fld_mag(hold_r.b_num);
  assign bd_m = fld_mag(hold_r.b_den);
  assign uses_b = (op != OP_NORM) && (op != OP_NEG);

  assign q_push = vld_r && !q_full;

  always_comb begin
    q_data        = '0;
    q_data.op     = op;
    q_data.na     = an_s ^ ad_s;
    q_data.nb     = bn_s ^ bd_s;
    q_data.an     = an_m;
    q_data.ad     = ad_m;
    q_data.bn     = bn_m;
    q_data.bd     = bd_m;
    if (ad_m == '0 || (uses_b && bd_m == '0) || (op == OP_DIV && bn_m == '0)) begin
      q_data.direct     = 1'b1;
      q_data.res.status = ST_ZERO_DEN;
    end
  end
endmodule

### sv/rau_queue.sv
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"
module rau_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rau_pkg::job_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output rau_pkg::job_t head
);
  import rau_pkg::*;

  job_t         mem_r [QDEPTH];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'(QDEPTH));
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `RAU_ASSERT_IMP(a_no_overflow, full, !push)
  `RAU_ASSERT_IMP(a_no_underflow, !not_empty, !pop)
  `RAU_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 2'(QDEPTH))
endmodule

### sv/rau_back.sv
// Back part: cross products, add, binary gcd, restoring divides and range check.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"
module rau_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rau_pkg::job_t       job,
  output logic                q_pop,
  output logic                out_valid,
  output rau_pkg::out_beat_t  out_beat
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_GFIN, S_DIVN, S_DIVD, S_CHK
  } st_t;

  st_t               st_r;
  job_t              j_r;
  logic [MAG_W-1:0]  p1_r, p2_r, p3_r, p4_r;    // an*bd, bn*ad, an*bn, ad*bd
  logic [MAG_W-1:0]  num_r, den_r;
  logic              neg_r;
  logic [MAG_W-1:0]  gx_r, gy_r;
  logic [6:0]        gk_r;
  logic [MAG_W-1:0]  q_r, rem_r, dvd_r;
  logic [6:0]        cnt_r;
  logic [MAG_W-1:0]  g_r;
  logic              cmp_r;
  out_beat_t         ob_r;
  logic              ov_r;

  logic [MAG_W-1:0]  half;
  logic [MAG_W:0]    rtry;
  logic [MAG_W-1:0]  t1m, t2m;
  logic              t1n, t2n;
  logic              pn, qn;

  assign half = MAG_W'(1) << (VALUE_WIDTH-1);
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_beat  = ob_r;
  assign rtry = {rem_r, dvd_r[MAG_W-1]} - {1'b0, g_r};

  assign t1m = p1_r;
  assign t2m = p2_r;
  assign t1n = j_r.na;
  assign t2n = (j_r.op == OP_SUB) ? ~j_r.nb : j_r.nb;
  assign pn  = j_r.na && t1m != '0;
  assign qn  = j_r.nb && t2m != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          j_r <= job;
          if (job.direct) begin
            ob_r <= job.res;
            ov_r <= 1'b1;
          end else begin
            st_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1_r <= MAG_W'(j_r.an) * MAG_W'(j_r.bd);
          p2_r <= MAG_W'(j_r.bn) * MAG_W'(j_r.ad);
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          p3_r <= MAG_W'(j_r.an) * MAG_W'(j_r.bn);
          p4_r <= MAG_W'(j_r.ad) * MAG_W'(j_r.bd);
          st_r <= S_COMB;
        end
        S_COMB: begin
          unique case (j_r.op)
            OP_NORM, OP_NEG: begin
              neg_r <= (j_r.op == OP_NEG) ? ~j_r.na : j_r.na;
              num_r <= MAG_W'(j_r.an);
              den_r <= MAG_W'(j_r.ad);
            end
            OP_ADD, OP_SUB: begin
              den_r <= p4_r;
              if (t1n == t2n) begin
                neg_r <= t1n; num_r <= t1m + t2m;
              end else if (t1m >= t2m) begin
                neg_r <= t1n; num_r <= t1m - t2m;
              end else begin
                neg_r <= t2n; num_r <= t2m - t1m;
              end
            end
            OP_MUL: begin
              neg_r <= j_r.na ^ j_r.nb; num_r <= p3_r; den_r <= p4_r;
            end
            OP_DIV: begin
              neg_r <= j_r.na ^ j_r.nb; num_r <= p1_r;
              den_r <= MAG_W'(j_r.ad) * MAG_W'(j_r.bn);
            end
            OP_EQ, OP_LT: begin
              if (j_r.op == OP_EQ) cmp_r <= (pn == qn) && (t1m == t2m);
              else if (pn != qn) cmp_r <= pn;
              else if (pn) cmp_r <= t1m > t2m;
              else cmp_r <= t1m < t2m;
            end
            default: ;
          endcase
          st_r <= (j_r.op == OP_EQ || j_r.op == OP_LT) ? S_CHK : S_GCD;
          gk_r <= '0;
          if (j_r.op == OP_EQ || j_r.op == OP_LT) ob_r <= '0;
        end
        S_GCD: begin
          if (gk_r == 7'd0) begin
            gx_r <= num_r; gy_r <= den_r; gk_r <= 7'd1;
          end else if (gx_r == '0) begin
            g_r <= gy_r << (gk_r - 7'd1); st_r <= S_GFIN;
          end else if (!gx_r[0] && !gy_r[0]) begin
            gx_r <= gx_r >> 1; gy_r <= gy_r >> 1; gk_r <= gk_r + 7'd1;
          end else if (!gx_r[0]) begin
            gx_r <= gx_r >> 1;
          end else if (!gy_r[0]) begin
            gy_r <= gy_r >> 1;
          end else if (gx_r >= gy_r) begin
            gx_r <= (gx_r - gy_r) >> 1;
          end else begin
            gy_r <= (gy_r - gx_r) >> 1;
          end
        end
        S_GFIN: begin
          dvd_r <= num_r; rem_r <= '0; q_r <= '0; cnt_r <= 7'(MAG_W);
          st_r <= S_DIVN;
        end
        S_DIVN, S_DIVD: begin
          if (cnt_r == 7'd0) begin
            if (st_r == S_DIVN) begin
              num_r <= q_r; dvd_r <= den_r; rem_r <= '0; q_r <= '0;
              cnt_r <= 7'(MAG_W); st_r <= S_DIVD;
            end else begin
              den_r <= q_r; st_r <= S_CHK;
            end
          end else begin
            dvd_r <= dvd_r << 1;
            cnt_r <= cnt_r - 7'd1;
            if (!rtry[MAG_W]) begin
              rem_r <= rtry[MAG_W-1:0]; q_r <= {q_r[MAG_W-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[MAG_W-2:0], dvd_r[MAG_W-1]}; q_r <= {q_r[MAG_W-2:0], 1'b0};
            end
          end
        end
        S_CHK: begin
          ov_r <= 1'b1;
          ob_r <= '0;
          st_r <= S_IDLE;
          if (j_r.op == OP_EQ || j_r.op == OP_LT) begin
            ob_r.compare_true <= cmp_r;
          end else if (den_r > half - 1 ||
                       num_r > ((neg_r && num_r != '0) ? half : half - 1)) begin
            ob_r.status <= ST_OVERFLOW;
          end else begin
            ob_r.res_num <= (neg_r && num_r != '0) ? 32'(~num_r + 1'b1) : 32'(num_r);
            ob_r.res_den <= 31'(den_r);
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `RAU_ASSERT_NXT(a_pop_leaves_idle, q_pop && !job.direct, st_r == S_MUL1)
  `RAU_ASSERT_IMP(a_out_status, ov_r, ob_r.status != ST_RSVD)
  `RAU_ASSERT_IMP(a_no_pop_busy, st_r != S_IDLE, !q_pop)
endmodule

### sv/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: front, job queue and back.
//  channel | direction | handshake     | payload
//  in      | input     | start / busy  | in_beat (operation, a/b fractions)
//  out     | output    | out_valid     | out_beat (res_num, res_den, compare, status)
// An arithmetic item runs through the binary gcd loop and the two restoring divides in
// the back part; comparisons skip them, and zero-denominator items pass the back part
// straight from its idle state.
// Reset is synchronous, active low, and empties the queue.
// The front accepts a new item while the back works, until the two-entry queue fills.
// Results appear on out_valid for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module rational_arithmetic_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rau_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  output rau_pkg::out_beat_t  out_beat
);
  import rau_pkg::*;

  logic q_push, q_full, q_pop, q_ne;
  job_t q_in, q_head;

  rau_front u_front (.clk, .rst_n, .start, .in_beat, .q_full, .busy,
                     .q_push, .q_data(q_in));
  rau_queue u_queue (.clk, .rst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
                     .full(q_full), .not_empty(q_ne), .head(q_head));
  rau_back  u_back  (.clk, .rst_n, .q_valid(q_ne), .job(q_head), .q_pop,
                     .out_valid, .out_beat);
endmodule

### tb/rational_arithmetic_unit_tb.sv
// Testbench for the rational arithmetic unit: random and directed fractions checked against a predictor.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int WD_LIMIT = 20000;
  localparam int N_RANDOM = 1850;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_beat_t in_beat = '0;
  logic out_valid;
  out_beat_t out_beat;

  in_beat_t pending_q[$];
  out_beat_t expected_q[$];
  int errors = 0;
  int wd_count = 0;
  bit stim_done = 1'b0;
  bit drain_req = 1'b0;
  int gap_left = 0;
  bit calm = 1'b0;

  always #10 clk = ~clk;

  rational_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_beat_t predict_fraction(in_beat_t b);
    out_beat_t r;
    op_t op;
    logic [63:0] an, ad, bn, bd, t1m, t2m, nm, dn, g;
    logic sa, sb, t1n, t2n, nn, uses_b;
    logic [63:0] half;
    r = '0;
    op = op_t'(b.operation);
    an = b.a_num[31] ? 64'(-$signed(65'(b.a_num))) : 64'(b.a_num);
    ad = b.a_den[31] ? 64'(-$signed(65'(b.a_den))) : 64'(b.a_den);
    bn = b.b_num[31] ? 64'(-$signed(65'(b.b_num))) : 64'(b.b_num);
    bd = b.b_den[31] ? 64'(-$signed(65'(b.b_den))) : 64'(b.b_den);
    sa = b.a_num[31] ^ b.a_den[31];
    sb = b.b_num[31] ^ b.b_den[31];
    uses_b = (op != OP_NORM && op != OP_NEG);
    if (ad == 0 || (uses_b && bd == 0) || (op == OP_DIV && bn == 0)) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    t1n = sa; t1m = an * bd;
    t2n = sb; t2m = bn * ad;
    case (op)
      OP_NORM, OP_NEG: begin
        nn = (op == OP_NEG) ? !sa : sa;
        nm = an;
        dn = ad;
      end
      OP_ADD, OP_SUB: begin
        if (op == OP_SUB) t2n = !t2n;
        if (t1n == t2n) begin
          nn = t1n; nm = t1m + t2m;
        end else if (t1m >= t2m) begin
          nn = t1n; nm = t1m - t2m;
        end else begin
          nn = t2n; nm = t2m - t1m;
        end
        dn = ad * bd;
      end
      OP_MUL: begin
        nn = sa ^ sb; nm = an * bn; dn = ad * bd;
      end
      OP_DIV: begin
        nn = sa ^ sb; nm = t1m; dn = ad * bn;
      end
      default: begin
        logic p_neg, q_neg;
        int c;
        p_neg = t1n && t1m != 0;
        q_neg = t2n && t2m != 0;
        if (p_neg != q_neg) c = p_neg ? -1 : 1;
        else if (t1m == t2m) c = 0;
        else if (p_neg) c = (t1m > t2m) ? -1 : 1;
        else c = (t1m < t2m) ? -1 : 1;
        r.compare_true = (op == OP_EQ) ? (c == 0) : (c < 0);
        r.status = ST_OK;
        return r;
      end
    endcase
    g = gcd64(nm, dn);
    nm = nm / g;
    dn = dn / g;
    if (nm == 0) nn = 1'b0;
    half = 64'd1 << (VALUE_WIDTH - 1);
    if (dn > half - 1 || nm > (nn ? half : half - 1)) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.res_num = nn ? 32'(-nm) : 32'(nm);
    r.res_den = 31'(dn);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(-$signed(32'($urandom_range(1, 16))));
      3, 4, 5: return 32'($urandom_range(0, 40));
      6: return 32'(-$signed(32'($urandom_range(0, 1000))));
      7: return 32'($urandom_range(0, 65535)) * 32'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  function automatic in_beat_t make_beat(op_t op, logic [31:0] an, logic [31:0] ad,
                                         logic [31:0] bn, logic [31:0] bd);
    in_beat_t b;
    b.operation = op;
    b.a_num = an; b.a_den = ad; b.b_num = bn; b.b_den = bd;
    return b;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        void'(pending_q.pop_front());
      end
      if (start && busy) begin
        // hold the beat until accepted
      end else if (drain_req && expected_q.size() == 0 && !(start && !busy)) begin
        drain_req <= 1'b0;
        start <= 1'b0;
      end else if (drain_req) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() > ((start && !busy) ? 0 : 0)) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(1, 19);
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          in_beat <= pending_q[0];
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // records expectation on acceptance, checks results
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (rst_n) begin
      if (start && !busy) begin
        expected_q.push_back(predict_fraction(in_beat));
      end
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation: %p", out_beat);
          errors++;
        end else begin
          exp_beat = expected_q.pop_front();
          if (out_beat.res_num !== exp_beat.res_num) begin
            $error("res_num exp %0d got %0d", exp_beat.res_num, out_beat.res_num);
            errors++;
          end
          if (out_beat.res_den !== exp_beat.res_den) begin
            $error("res_den exp %0d got %0d", exp_beat.res_den, out_beat.res_den);
            errors++;
          end
          if (out_beat.compare_true !== exp_beat.compare_true) begin
            $error("compare_true exp %0b got %0b", exp_beat.compare_true,
                   out_beat.compare_true);
            errors++;
          end
          if (out_beat.status !== exp_beat.status) begin
            $error("status exp %0d got %0d", exp_beat.status, out_beat.status);
            errors++;
          end
        end
      end
      if ((start && !busy) || out_valid) wd_count <= 0;
      else wd_count <= wd_count + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (wd_count >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    op_t op;
    for (i = 0; i < 8; i++) begin
      op = op_t'(i);
      pending_q.push_back(make_beat(op, 32'sd3, -32'sd6, 32'sd5, 32'sd10));
    end
    pending_q.push_back(make_beat(OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd2));
    pending_q.push_back(make_beat(OP_EQ, 32'sd1, 32'sd2, 32'sd1, 32'sd0));
    pending_q.push_back(make_beat(OP_DIV, 32'sd1, 32'sd2, 32'sd0, 32'sd3));
    pending_q.push_back(make_beat(OP_NEG, 32'h8000_0000, 32'sd1, 32'sd0, 32'sd0));
    pending_q.push_back(make_beat(OP_NORM, 32'h8000_0000, -32'sd1, 32'sd0, 32'sd0));
    pending_q.push_back(make_beat(OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'sd0, 32'sd0));
    pending_q.push_back(make_beat(OP_MUL, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1));
    pending_q.push_back(make_beat(OP_MUL, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h8000_0000, 32'h7fff_ffff));
    pending_q.push_back(make_beat(OP_SUB, 32'sd1, 32'sd3, 32'sd1, 32'sd3));
    pending_q.push_back(make_beat(OP_ADD, 32'sd1, 32'h7fff_ffff, 32'sd1, 32'h7fff_fffe));
    pending_q.push_back(make_beat(OP_LT, -32'sd1, 32'sd2, 32'sd1, -32'sd2));
    pending_q.push_back(make_beat(OP_LT, -32'sd1, 32'sd3, 32'sd1, -32'sd2));
    pending_q.push_back(make_beat(OP_EQ, 32'sd0, -32'sd5, 32'sd0, 32'sd7));
    pending_q.push_back(make_beat(OP_DIV, 32'h8000_0000, 32'sd1, -32'sd1, 32'sd1));
    pending_q.push_back(make_beat(OP_NORM, 32'sd0, 32'h8000_0000, 32'sd0, 32'sd0));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0);
    drain_req <= 1'b1;
    @(posedge clk);
    wait (drain_req == 1'b0);
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) calm = 1'b1;
      pending_q.push_back(make_beat(op_t'($urandom_range(0, 7)), rand_value(),
                                    rand_value(), rand_value(), rand_value()));
      if (pending_q.size() >= 8) wait (pending_q.size() < 4);
    end
    wait (pending_q.size() == 0);
    @(posedge clk);
    wait (expected_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
